FILE: hdl/fvg_pkg.sv
package fvg_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SMALL   = 2'd2,
    ST_LARGE   = 2'd3
  } status_e;

  // Requested type codes
  localparam logic [1:0] TYPE_AUTO  = 2'd0;
  localparam logic [1:0] TYPE_FAT16 = 2'd1;
  localparam logic [1:0] TYPE_FAT32 = 2'd2;
  localparam logic [1:0] TYPE_BAD   = 2'd3;

  // Cluster count limits
  localparam logic [31:0] FAT16_MIN_CLU   = 32'd4085;
  localparam logic [31:0] FAT16_MAX_CLU   = 32'd65524;
  localparam logic [31:0] FAT32_MIN_CLU   = 32'd65525;
  localparam logic [31:0] FAT32_MAX_CLU   = 32'h0fff_fff5;
  localparam logic [31:0] FAT16_ENTRY_CAP = 32'h7fff_fffd;
  localparam logic [31:0] FAT32_ENTRY_CAP = 32'h3fff_fffd;
  localparam logic [23:0] FAT16_MAX_LEN   = 24'h00_ffff;

  // Volume size at which automatic type selection moves to FAT32
  localparam logic [31:0] AUTO_FAT32_SIZE = 32'd1048576;

  // Fixed layout per type
  localparam logic [5:0] FAT16_RSVD_CNT = 6'd1;
  localparam logic [5:0] FAT32_RSVD_CNT = 6'd32;
  localparam logic [5:0] FAT16_ROOT     = 6'd32;
  localparam logic [5:0] FAT32_ROOT     = 6'd0;

  // Log2 of the starting cluster size from the volume size
  function automatic logic [2:0] start_shift(input logic [31:0] total, input logic is32);
    logic [2:0] sh;
    if (!is32) begin
      if      (total <= 32'd262144)  sh = 3'd2;
      else if (total <= 32'd524288)  sh = 3'd3;
      else if (total <= 32'd1048576) sh = 3'd4;
      else if (total <= 32'd2097152) sh = 3'd5;
      else if (total <= 32'd4194304) sh = 3'd6;
      else                           sh = 3'd7;
    end else begin
      if      (total <= 32'd532480)   sh = 3'd0;
      else if (total <= 32'd16777216) sh = 3'd3;
      else if (total <= 32'd33554432) sh = 3'd4;
      else if (total <= 32'd67108864) sh = 3'd5;
      else                            sh = 3'd6;
    end
    return sh;
  endfunction

  // Bit position of a one-hot cluster size
  function automatic logic [2:0] size_shift(input logic [7:0] spc);
    logic [2:0] sh;
    sh = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (spc[i]) sh = 3'(i);
    end
    return sh;
  endfunction

endpackage

FILE: hdl/fat_volume_geometry_solver.sv
// FAT16/FAT32 format geometry solver. One request (volume size, type or auto,
// cluster size or auto) gives one result with status and layout; failed
// results carry zero layout fields. A single add/shift/compare datapath is
// stepped by a sequencer: each attempt at one cluster size runs a binary
// search over the table length (at most 23 steps) with setup before it and a
// final check and resolve after it; an attempt that fails early is shorter.
// Automatic cluster size runs up to 16 attempts. The input stalls while a
// request is in work; a finished result sits in the output register and a
// new request may be taken meanwhile.
module fat_volume_geometry_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] total_sectors_i,
  input  logic [1:0]  requested_type_i,
  input  logic [7:0]  requested_cluster_size_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        fat_type_o,
  output logic [7:0]  cluster_size_o,
  output logic [5:0]  reserved_count_o,
  output logic [5:0]  root_dir_sectors_o,
  output logic [21:0] table_sectors_o,
  output logic [31:0] data_begin_o,
  output logic [27:0] cluster_total_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_START, S_MID, S_CLU, S_NEED, S_RESOLVE
  } state_e;

  typedef enum logic [1:0] {
    PH_INIT, PH_SEARCH, PH_FINAL
  } phase_e;

  state_e              state_q;
  phase_e              phase_q;
  fvg_pkg::status_e    st_q;
  logic [31:0]         total_q;
  logic [1:0]          rtype_q;
  logic [7:0]          rspc_q;
  logic                is32_q;
  logic                auto_q;
  logic [2:0]          sh_q;
  logic [3:0]          tries_q;
  logic [31:0]         base_q;
  logic [31:0]         cap_q;
  logic [23:0]         lo_q;
  logic [23:0]         hi_q;
  logic [23:0]         len_q;
  logic [31:0]         clu_q;

  logic                out_valid_q;
  logic [1:0]          status_q;
  logic                fat_type_q;
  logic [7:0]          cluster_size_q;
  logic [5:0]          reserved_q;
  logic [5:0]          root_q;
  logic [21:0]         table_q;
  logic [31:0]         begin_q;
  logic [27:0]         clusters_q;

  // Shared datapath
  logic [5:0]  fixed;
  logic [32:0] diff;
  logic [31:0] clu_calc;
  logic [34:0] bytes;
  logic [25:0] need;
  logic [23:0] mid;
  logic [31:0] entry_cap;
  logic        spc_bad;
  logic        out_free;
  logic        is32_req;
  logic        retry_down;
  logic        retry_up;
  logic        deliver;

  always_comb begin
    fixed     = is32_q ? (fvg_pkg::FAT32_RSVD_CNT + fvg_pkg::FAT32_ROOT)
                       : (fvg_pkg::FAT16_RSVD_CNT + fvg_pkg::FAT16_ROOT);
    diff      = {1'b0, base_q} - {8'd0, len_q, 1'b0};
    clu_calc  = 32'(diff >> sh_q);
    bytes     = ({3'd0, clu_q} + 35'd2) << (is32_q ? 2 : 1);
    need      = 26'((bytes + 35'd511) >> 9);
    mid       = lo_q + ((hi_q - lo_q) >> 1);
    entry_cap = is32_q ? fvg_pkg::FAT32_ENTRY_CAP : fvg_pkg::FAT16_ENTRY_CAP;
    spc_bad   = (rspc_q != 8'd0) && ((rspc_q & (rspc_q - 8'd1)) != 8'd0);
    is32_req  = (rtype_q == fvg_pkg::TYPE_AUTO) ? (total_q >= fvg_pkg::AUTO_FAT32_SIZE)
                                                : (rtype_q == fvg_pkg::TYPE_FAT32);
    out_free  = !out_valid_q || !out_stall_i;
    // Retry decisions after an attempt, and delivery of the transaction
    retry_down = auto_q && (tries_q != 4'd15) && (st_q == fvg_pkg::ST_SMALL) &&
                 (sh_q != 3'd0);
    retry_up   = auto_q && (tries_q != 4'd15) && (st_q == fvg_pkg::ST_LARGE) &&
                 (sh_q != 3'd7);
    deliver    = (state_q == S_RESOLVE) && !retry_down && !retry_up && out_free;
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign fat_type_o         = fat_type_q;
  assign cluster_size_o     = cluster_size_q;
  assign reserved_count_o   = reserved_q;
  assign root_dir_sectors_o = root_q;
  assign table_sectors_o    = table_q;
  assign data_begin_o       = begin_q;
  assign cluster_total_o    = clusters_q;

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_INIT;
      st_q        <= fvg_pkg::ST_INVALID;
      out_valid_q <= 1'b0;
      tries_q     <= '0;
    end else begin
      // Output valid: set on delivery, cleared once taken
      if (deliver) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            total_q <= total_sectors_i;
            rtype_q <= requested_type_i;
            rspc_q  <= requested_cluster_size_i;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          is32_q  <= is32_req;
          tries_q <= '0;
          auto_q  <= (rspc_q == 8'd0);
          sh_q    <= (rspc_q == 8'd0) ? fvg_pkg::start_shift(total_q, is32_req)
                                      : fvg_pkg::size_shift(rspc_q);
          if (rtype_q == fvg_pkg::TYPE_BAD || spc_bad) begin
            st_q    <= fvg_pkg::ST_INVALID;
            state_q <= S_RESOLVE;
          end else begin
            state_q <= S_START;
          end
        end
        // Begin one attempt at the current cluster size
        S_START: begin
          if (total_q <= 32'(fixed) + 32'd2) begin
            st_q    <= fvg_pkg::ST_INVALID;
            state_q <= S_RESOLVE;
          end else begin
            base_q  <= total_q - 32'(fixed);
            cap_q   <= (total_q - 32'(fixed)) >> 1;
            len_q   <= 24'd1;
            phase_q <= PH_INIT;
            state_q <= S_CLU;
          end
        end
        // One binary-search step, or the end of the search
        S_MID: begin
          if (lo_q < hi_q) begin
            if (32'(mid) > cap_q) begin
              lo_q <= mid + 24'd1;
            end else begin
              len_q   <= mid;
              phase_q <= PH_SEARCH;
              state_q <= S_CLU;
            end
          end else if (32'(lo_q) > cap_q) begin
            st_q    <= fvg_pkg::ST_INVALID;
            state_q <= S_RESOLVE;
          end else begin
            len_q   <= lo_q;
            phase_q <= PH_FINAL;
            state_q <= S_CLU;
          end
        end
        S_CLU: begin
          clu_q   <= clu_calc;
          state_q <= S_NEED;
        end
        // Table sectors needed for the cluster count
        S_NEED: begin
          case (phase_q)
            PH_INIT: begin
              if (clu_q > entry_cap) begin
                st_q    <= fvg_pkg::ST_INVALID;
                state_q <= S_RESOLVE;
              end else begin
                hi_q    <= (need == 26'd0) ? 24'd1 : need[23:0];
                lo_q    <= 24'd1;
                state_q <= S_MID;
              end
            end
            PH_SEARCH: begin
              if (need <= 26'(len_q)) hi_q <= len_q;
              else                    lo_q <= len_q + 24'd1;
              state_q <= S_MID;
            end
            PH_FINAL: begin
              state_q <= S_RESOLVE;
              if (need > 26'(lo_q) || clu_q == 32'd0) begin
                st_q <= fvg_pkg::ST_INVALID;
              end else if (!is32_q) begin
                if (clu_q < fvg_pkg::FAT16_MIN_CLU) st_q <= fvg_pkg::ST_SMALL;
                else if (clu_q > fvg_pkg::FAT16_MAX_CLU || lo_q > fvg_pkg::FAT16_MAX_LEN)
                  st_q <= fvg_pkg::ST_LARGE;
                else st_q <= fvg_pkg::ST_OK;
              end else begin
                if (clu_q < fvg_pkg::FAT32_MIN_CLU) st_q <= fvg_pkg::ST_SMALL;
                else if (clu_q > fvg_pkg::FAT32_MAX_CLU) st_q <= fvg_pkg::ST_LARGE;
                else st_q <= fvg_pkg::ST_OK;
              end
            end
            default: state_q <= S_RESOLVE;
          endcase
        end
        // Retry with another cluster size, or deliver the transaction
        S_RESOLVE: begin
          if (retry_down) begin
            sh_q    <= sh_q - 3'd1;
            tries_q <= tries_q + 4'd1;
            state_q <= S_START;
          end else if (retry_up) begin
            sh_q    <= sh_q + 3'd1;
            tries_q <= tries_q + 4'd1;
            state_q <= S_START;
          end else if (deliver) begin
            status_q    <= st_q;
            if (st_q == fvg_pkg::ST_OK) begin
              fat_type_q     <= is32_q;
              cluster_size_q <= 8'd1 << sh_q;
              reserved_q     <= is32_q ? fvg_pkg::FAT32_RSVD_CNT : fvg_pkg::FAT16_RSVD_CNT;
              root_q         <= is32_q ? fvg_pkg::FAT32_ROOT : fvg_pkg::FAT16_ROOT;
              table_q        <= lo_q[21:0];
              begin_q        <= 32'(fixed) + {7'd0, lo_q, 1'b0};
              clusters_q     <= clu_q[27:0];
            end else begin
              fat_type_q     <= 1'b0;
              cluster_size_q <= '0;
              reserved_q     <= '0;
              root_q         <= '0;
              table_q        <= '0;
              begin_q        <= '0;
              clusters_q     <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: test/fat_volume_geometry_solver_test.sv
`timescale 1ns / 1ps

module fat_volume_geometry_solver_test;

  localparam longint unsigned SECTOR_BYTES = 512;
  localparam longint unsigned TABLE_COPIES = 2;
  localparam int RANDOM_REQUESTS = 1850;
  localparam int HOLD_OFF_CYCLES = 2000;

  // One solved layout, at the widths of the result ports
  typedef struct packed {
    fvg_pkg::status_e status;
    logic        fat32;
    logic [7:0]  spc;
    logic [5:0]  reserved;
    logic [5:0]  root_len;
    logic [21:0] table_len;
    logic [31:0] data_begin;
    logic [27:0] clusters;
  } layout_t;

  // Geometry predictor plus the queue of layouts still owed by the block
  class layout_scoreboard;
    layout_t pending_layouts[$];
    int failures;

    function new();
      failures = 0;
    endfunction

    // Sectors needed to hold table entries for a cluster count
    function longint unsigned table_need(longint unsigned clusters, longint unsigned esize);
      return ((clusters + 2) * esize + SECTOR_BYTES - 1) / SECTOR_BYTES;
    endfunction

    // One attempt at a fixed type and cluster size
    function layout_t fit_table(longint unsigned total, bit is32, longint unsigned spc);
      layout_t r;
      longint unsigned rsv, root, esize, fixed, cap, lo, hi, mid, clusters;
      r = '0;
      r.status = fvg_pkg::ST_INVALID;
      rsv = is32 ? 32 : 1;
      root = is32 ? 0 : 32;
      esize = is32 ? 4 : 2;
      fixed = rsv + root;
      if (spc == 0 || total <= fixed + TABLE_COPIES) return r;
      clusters = (total - fixed - TABLE_COPIES) / spc;
      if (clusters > (64'hffff_ffff / esize) - 2) return r;
      cap = (total - fixed) / TABLE_COPIES;
      hi = table_need(clusters, esize);
      if (hi == 0) hi = 1;
      lo = 1;
      // Smallest table length whose entries cover the remaining clusters
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (mid > cap) begin
          lo = mid + 1;
        end else begin
          clusters = (total - fixed - TABLE_COPIES * mid) / spc;
          if (table_need(clusters, esize) <= mid) hi = mid;
          else lo = mid + 1;
        end
      end
      if (lo > cap) return r;
      clusters = (total - fixed - TABLE_COPIES * lo) / spc;
      if (table_need(clusters, esize) > lo || clusters == 0) return r;
      // Cluster count window of the type
      if (!is32) begin
        if (clusters < 4085) begin
          r.status = fvg_pkg::ST_SMALL;
          return r;
        end
        if (clusters > 65524 || lo > 64'hffff) begin
          r.status = fvg_pkg::ST_LARGE;
          return r;
        end
      end else begin
        if (clusters < 65525) begin
          r.status = fvg_pkg::ST_SMALL;
          return r;
        end
        if (clusters > 64'h0fff_fff5) begin
          r.status = fvg_pkg::ST_LARGE;
          return r;
        end
      end
      r.status = fvg_pkg::ST_OK;
      r.fat32 = is32;
      r.spc = spc[7:0];
      r.reserved = rsv[5:0];
      r.root_len = root[5:0];
      r.table_len = lo[21:0];
      r.data_begin = 32'(fixed + TABLE_COPIES * lo);
      r.clusters = clusters[27:0];
      return r;
    endfunction

    // Starting cluster size in automatic mode
    function longint unsigned first_cluster_size(longint unsigned total, bit is32);
      if (!is32) begin
        if (total <= 262144) return 4;
        if (total <= 524288) return 8;
        if (total <= 1048576) return 16;
        if (total <= 2097152) return 32;
        if (total <= 4194304) return 64;
        return 128;
      end
      if (total <= 532480) return 1;
      if (total <= 16777216) return 8;
      if (total <= 33554432) return 16;
      if (total <= 67108864) return 32;
      return 64;
    endfunction

    // Full request: validation, type choice, cluster size retries
    function layout_t solve_layout(logic [31:0] total, logic [1:0] rtype, logic [7:0] rspc);
      layout_t r;
      bit is32;
      longint unsigned spc;
      r = '0;
      r.status = fvg_pkg::ST_INVALID;
      if (rtype == fvg_pkg::TYPE_BAD || (rspc != 0 && (rspc & (rspc - 8'd1)) != 0)) return r;
      if (rtype == fvg_pkg::TYPE_AUTO) is32 = (total >= fvg_pkg::AUTO_FAT32_SIZE);
      else is32 = (rtype == fvg_pkg::TYPE_FAT32);
      if (rspc != 0) return fit_table(total, is32, rspc);
      spc = first_cluster_size(total, is32);
      for (int n = 0; n < 16; n++) begin
        r = fit_table(total, is32, spc);
        if (r.status == fvg_pkg::ST_SMALL && spc > 1) spc = spc >> 1;
        else if (r.status == fvg_pkg::ST_LARGE && spc < 128) spc = spc << 1;
        else break;
      end
      return r;
    endfunction

    function void note_request(logic [31:0] total, logic [1:0] rtype, logic [7:0] rspc);
      pending_layouts.push_back(solve_layout(total, rtype, rspc));
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_layout(layout_t got);
      layout_t want;
      if (pending_layouts.size() == 0) begin
        $display("%0t: result with no request outstanding, status %0d", $time, got.status);
        failures++;
        return;
      end
      want = pending_layouts.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("fat_type", want.fat32, got.fat32);
      compare_field("cluster_size", want.spc, got.spc);
      compare_field("reserved_count", want.reserved, got.reserved);
      compare_field("root_dir_sectors", want.root_len, got.root_len);
      compare_field("table_sectors", want.table_len, got.table_len);
      compare_field("data_begin", want.data_begin, got.data_begin);
      compare_field("cluster_total", want.clusters, got.clusters);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] total_sectors_i;
  logic [1:0]  requested_type_i;
  logic [7:0]  requested_cluster_size_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic        fat_type_o;
  logic [7:0]  cluster_size_o;
  logic [5:0]  reserved_count_o;
  logic [5:0]  root_dir_sectors_o;
  logic [21:0] table_sectors_o;
  logic [31:0] data_begin_o;
  logic [27:0] cluster_total_o;

  layout_scoreboard board = new();
  int sent_count = 0;
  int idle_mode = 1;
  bit held_off = 1'b0;

  fat_volume_geometry_solver u_top (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid_i),
    .in_stall_o               (in_stall_o),
    .total_sectors_i          (total_sectors_i),
    .requested_type_i         (requested_type_i),
    .requested_cluster_size_i (requested_cluster_size_i),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall_i),
    .status_o                 (status_o),
    .fat_type_o               (fat_type_o),
    .cluster_size_o           (cluster_size_o),
    .reserved_count_o         (reserved_count_o),
    .root_dir_sectors_o       (root_dir_sectors_o),
    .table_sectors_o          (table_sectors_o),
    .data_begin_o             (data_begin_o),
    .cluster_total_o          (cluster_total_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: none in quiet phases, else mostly short with a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (idle_mode == 0) return 0;
    if (roll < (idle_mode == 1 ? 70 : 30)) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Volume sizes spread over the interesting regions
  function automatic logic [31:0] pick_total();
    logic [31:0] mark;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 200);
      2: return $urandom_range(4000, 300000);
      3: return $urandom_range(300000, 8388608);
      4: return $urandom_range(1048576, 134217728);
      5: begin
        case ($urandom_range(0, 9))
          0: mark = 32'd262144;
          1: mark = 32'd524288;
          2: mark = 32'd1048576;
          3: mark = 32'd2097152;
          4: mark = 32'd4194304;
          5: mark = 32'd532480;
          6: mark = 32'd16777216;
          7: mark = 32'd33554432;
          8: mark = 32'd67108864;
          default: mark = 32'd36;
        endcase
        return mark + $urandom_range(0, 8) - 32'd4;
      end
      6: return $urandom_range(0, 65536);
      7: return 32'hffff_ffff - $urandom_range(0, 1000);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [1:0] pick_type();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 10) return fvg_pkg::TYPE_AUTO;
    if (roll < 14) return fvg_pkg::TYPE_FAT16;
    if (roll < 18) return fvg_pkg::TYPE_FAT32;
    return fvg_pkg::TYPE_BAD;
  endfunction

  function automatic logic [7:0] pick_cluster_size();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return 8'd0;
    if (roll < 9) return 8'd1 << $urandom_range(0, 7);
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic drive_request(input logic [31:0] total, input logic [1:0] rtype,
                               input logic [7:0] rspc);
    int gap;
    total_sectors_i <= total;
    requested_type_i <= rtype;
    requested_cluster_size_i <= rspc;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(total, rtype, rspc);
    sent_count++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Result side stalls, with one long hold-off once traffic is flowing
  initial begin
    int hold;
    forever begin
      if (!held_off && sent_count >= 400) begin
        held_off = 1'b1;
        hold = HOLD_OFF_CYCLES;
      end else begin
        hold = pick_gap();
      end
      out_stall_i <= (hold != 0);
      repeat (hold == 0 ? 1 : hold) @(posedge clk_i);
    end
  end

  // Check every accepted result transaction
  initial begin
    layout_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got.status = fvg_pkg::status_e'(status_o);
        got.fat32 = fat_type_o;
        got.spc = cluster_size_o;
        got.reserved = reserved_count_o;
        got.root_len = root_dir_sectors_o;
        got.table_len = table_sectors_o;
        got.data_begin = data_begin_o;
        got.clusters = cluster_total_o;
        board.check_layout(got);
      end
    end
  end

  // Stimulus: reset, directed corners, then random requests
  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    total_sectors_i <= '0;
    requested_type_i <= fvg_pkg::TYPE_AUTO;
    requested_cluster_size_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Size extremes, bad type, bad cluster sizes, short volumes, type windows
    drive_request(32'd0, fvg_pkg::TYPE_AUTO, 8'd0);
    drive_request(32'hffff_ffff, fvg_pkg::TYPE_AUTO, 8'd0);
    drive_request(32'hffff_ffff, fvg_pkg::TYPE_FAT16, 8'd0);
    drive_request(32'hffff_ffff, fvg_pkg::TYPE_FAT16, 8'd1);
    drive_request(32'hffff_ffff, fvg_pkg::TYPE_FAT32, 8'd1);
    drive_request(32'hffff_ffff, fvg_pkg::TYPE_FAT32, 8'd128);
    drive_request(32'd1000000, fvg_pkg::TYPE_BAD, 8'd0);
    drive_request(32'd1000000, fvg_pkg::TYPE_FAT16, 8'd3);
    drive_request(32'd1000000, fvg_pkg::TYPE_AUTO, 8'd255);
    drive_request(32'd35, fvg_pkg::TYPE_FAT16, 8'd1);
    drive_request(32'd36, fvg_pkg::TYPE_FAT16, 8'd1);
    drive_request(32'd34, fvg_pkg::TYPE_FAT32, 8'd1);
    drive_request(32'd100, fvg_pkg::TYPE_FAT32, 8'd0);
    drive_request(32'd2000, fvg_pkg::TYPE_FAT16, 8'd4);
    drive_request(32'd8000000, fvg_pkg::TYPE_FAT16, 8'd8);
    drive_request(32'd100000, fvg_pkg::TYPE_FAT16, 8'd0);
    drive_request(32'd1048575, fvg_pkg::TYPE_AUTO, 8'd0);
    drive_request(32'd1048576, fvg_pkg::TYPE_AUTO, 8'd0);
    drive_request(32'd532480, fvg_pkg::TYPE_FAT32, 8'd0);
    drive_request(32'd532481, fvg_pkg::TYPE_FAT32, 8'd0);
    drive_request(32'd67108865, fvg_pkg::TYPE_AUTO, 8'd0);
    drive_request(32'd20000000, fvg_pkg::TYPE_FAT32, 8'd128);
    drive_request(32'd4194305, fvg_pkg::TYPE_FAT16, 8'd0);
    drive_request(32'd66000, fvg_pkg::TYPE_FAT32, 8'd1);

    // Random requests; the idle level changes every 150 transactions
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 150 == 0) idle_mode = $urandom_range(0, 2);
      drive_request(pick_total(), pick_type(), pick_cluster_size());
    end
    in_valid_i <= 1'b0;

    // Drain, then allow the block a full request time to misbehave
    while (board.pending_layouts.size() != 0) @(posedge clk_i);
    repeat (1500) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("fat_volume_geometry_solver: match");
    end else begin
      $display("fat_volume_geometry_solver: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("fat_volume_geometry_solver: mismatch");
    $finish;
  end

endmodule
